@@ design/tmva_pkg.sv @@
`default_nettype none
package tmva_pkg;

   localparam int ROWS = 32;
   localparam int COLUMNS = 32;
   localparam int LANES = 4;
   localparam int GROUPS = COLUMNS / LANES;
   localparam int ACT_WIDTH = 8;
   localparam int ACC_WIDTH = 32;
   localparam int SUM_WIDTH = 11;
   localparam int TERM_WIDTH = 10;
   localparam logic [1:0] CODE_MASK = 2'h3;

   typedef enum logic [1:0] {
      CMD_LOAD_ACT = 2'd0,
      CMD_WEIGHT   = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_READ     = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      CODE_MINUS_ONE = 2'd0,
      CODE_ZERO      = 2'd1,
      CODE_PLUS_ONE  = 2'd2,
      CODE_PLUS_TWO  = 2'd3
   } weight_code_type;

   // One weight-times-activation term; the weight is the code minus one.
   function automatic logic signed [TERM_WIDTH-1:0] tmva_term(
      input logic [1:0]                  code,
      input logic signed [ACT_WIDTH-1:0] act
   );
      logic signed [TERM_WIDTH-1:0] wide;
      logic signed [TERM_WIDTH-1:0] result;
      wide = TERM_WIDTH'(act);
      unique case (weight_code_type'(code & CODE_MASK))
         CODE_MINUS_ONE: result = -wide;
         CODE_ZERO:      result = '0;
         CODE_PLUS_ONE:  result = wide;
         CODE_PLUS_TWO:  result = wide <<< 1;
         default:        result = '0;
      endcase
      return result;
   endfunction

endpackage
`default_nettype wire

@@ design/tmva_ram.sv @@
`default_nettype none
module tmva_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ design/tmva_dot4.sv @@
`default_nettype none
module tmva_dot4
   import tmva_pkg::*;
(
   input  wire logic [LANES*ACT_WIDTH-1:0] act_word,
   input  wire logic [LANES-1:0]           lane_enable,
   input  wire logic [2*LANES-1:0]         weight_byte,
   output logic signed [SUM_WIDTH-1:0]     dot_sum
);

   always_comb begin
      logic signed [SUM_WIDTH-1:0] acc;
      acc = '0;
      for (int i = 0; i < LANES; i++) begin
         if (lane_enable[i]) begin
            acc = acc + SUM_WIDTH'(tmva_term(weight_byte[2*i +: 2],
                                             act_word[ACT_WIDTH*i +: ACT_WIDTH]));
         end
      end
      dot_sum = acc;
   end

endmodule
`default_nettype wire

@@ design/ternary_matvec_accumulate_top.sv @@
`default_nettype none
// Channel    | Ports                                   | Handshake
// -----------+-----------------------------------------+--------------------------
// request    | req_command, req_row_number,            | start high, busy low
//            | req_group_number, req_act_0..3,         |
//            | req_weight_byte                         |
// response   | rsp_read_row, rsp_row_total             | rsp_strobe, one cycle
//
// One transaction is taken every cycle; busy stays low and the receiver cannot stall.
// A read's response goes through the accumulator memory's read register, loaded at
// acceptance, and then through the response register.
// Each weight byte updates its accumulator through a read, add and write back;
// a one-entry forwarding register covers back-to-back updates of the same row.
// Reset and clear zero all accumulators at once through per-row valid bits.
module ternary_matvec_accumulate_top
   import tmva_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [4:0]  req_row_number,
   input  wire logic [2:0]  req_group_number,
   input  wire logic [7:0]  req_act_0,
   input  wire logic [7:0]  req_act_1,
   input  wire logic [7:0]  req_act_2,
   input  wire logic [7:0]  req_act_3,
   input  wire logic [7:0]  req_weight_byte,
   output logic             rsp_strobe,
   output logic [4:0]       rsp_read_row,
   output logic [31:0]      rsp_row_total
);

   localparam int ROW_ADDR_BITS = $clog2(ROWS);
   localparam int GROUP_ADDR_BITS = $clog2(GROUPS);

   logic        accept;
   command_type req_cmd;

   // Stage one: the memories' read data is valid here.
   logic        s1_valid_ff, s1_valid_in;
   command_type s1_cmd_ff;
   logic [4:0]  s1_row_ff;
   logic [2:0]  s1_group_ff;
   logic [7:0]  s1_weight_ff;

   logic                 fwd_valid_ff, fwd_valid_in;
   logic [4:0]           fwd_row_ff;
   logic [ACC_WIDTH-1:0] fwd_data_ff;

   logic [ROWS-1:0] acc_valid_ff, acc_valid_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [4:0]           rsp_row_ff;
   logic [ACC_WIDTH-1:0] rsp_total_ff, rsp_total_in;

   logic [LANES*ACT_WIDTH-1:0] act_rd_data;
   logic [ACC_WIDTH-1:0]       acc_rd_data;
   logic                       act_wr_en;
   logic                       acc_wr_en;
   logic [ACC_WIDTH-1:0]       acc_old;
   logic [ACC_WIDTH-1:0]       acc_new;
   logic signed [SUM_WIDTH-1:0] dot_sum;
   logic [LANES-1:0]           lane_enable;
   logic                       s1_row_ok;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign req_cmd = command_type'(req_command);

   assign act_wr_en = accept && (req_cmd == CMD_LOAD_ACT)
                      && (32'(req_group_number) < GROUPS);

   tmva_ram #(
      .WIDTH(LANES * ACT_WIDTH),
      .DEPTH(GROUPS)
   ) u_act_ram (
      .clock   (clock),
      .wr_en   (act_wr_en),
      .wr_addr (req_group_number[GROUP_ADDR_BITS-1:0]),
      .wr_data ({req_act_3, req_act_2, req_act_1, req_act_0}),
      .rd_en   (accept),
      .rd_addr (req_group_number[GROUP_ADDR_BITS-1:0]),
      .rd_data (act_rd_data)
   );

   tmva_ram #(
      .WIDTH(ACC_WIDTH),
      .DEPTH(ROWS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (s1_row_ff[ROW_ADDR_BITS-1:0]),
      .wr_data (acc_new),
      .rd_en   (accept),
      .rd_addr (req_row_number[ROW_ADDR_BITS-1:0]),
      .rd_data (acc_rd_data)
   );

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_enable[i] = (32'(s1_group_ff) * LANES + i) < COLUMNS;
      end
   end

   tmva_dot4 u_dot4 (
      .act_word    (act_rd_data),
      .lane_enable (lane_enable),
      .weight_byte (s1_weight_ff),
      .dot_sum     (dot_sum)
   );

   always_comb begin
      s1_row_ok = 32'(s1_row_ff) < ROWS;

      // The write of the previous transaction lands at the same edge as this
      // transaction's read, so the memory still returns the older value.
      priority if (fwd_valid_ff && (fwd_row_ff == s1_row_ff)) begin
         acc_old = fwd_data_ff;
      end else if (acc_valid_ff[s1_row_ff[ROW_ADDR_BITS-1:0]]) begin
         acc_old = acc_rd_data;
      end else begin
         acc_old = '0;
      end

      acc_new   = acc_old + ACC_WIDTH'(dot_sum);
      acc_wr_en = s1_valid_ff && (s1_cmd_ff == CMD_WEIGHT) && s1_row_ok;

      fwd_valid_in = acc_wr_en;

      acc_valid_in = acc_valid_ff;
      if (acc_wr_en) begin
         acc_valid_in[s1_row_ff[ROW_ADDR_BITS-1:0]] = 1'b1;
      end
      // A clear accepted now follows the update finishing now, so it wins.
      if (accept && (req_cmd == CMD_CLEAR)) begin
         acc_valid_in = '0;
         fwd_valid_in = 1'b0;
      end

      s1_valid_in   = accept;
      rsp_strobe_in = s1_valid_ff && (s1_cmd_ff == CMD_READ);
      rsp_total_in  = s1_row_ok ? acc_old : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         acc_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         acc_valid_ff  <= acc_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= req_cmd;
         s1_row_ff    <= req_row_number;
         s1_group_ff  <= req_group_number;
         s1_weight_ff <= req_weight_byte;
      end
      if (acc_wr_en) begin
         fwd_row_ff  <= s1_row_ff;
         fwd_data_ff <= acc_new;
      end
      if (rsp_strobe_in) begin
         rsp_row_ff   <= s1_row_ff;
         rsp_total_ff <= rsp_total_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_row  = rsp_row_ff;
   assign rsp_row_total = rsp_total_ff;

endmodule
`default_nettype wire

@@ tb/sv/tmva_checker.sv @@
`default_nettype none
module tmva_checker
   import tmva_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [4:0]  req_row_number,
   input  wire logic [2:0]  req_group_number,
   input  wire logic [7:0]  req_act_0,
   input  wire logic [7:0]  req_act_1,
   input  wire logic [7:0]  req_act_2,
   input  wire logic [7:0]  req_act_3,
   input  wire logic [7:0]  req_weight_byte,
   input  wire logic        rsp_strobe,
   input  wire logic [4:0]  rsp_read_row,
   input  wire logic [31:0] rsp_row_total,
   output int               fail_count,
   output int               totals_due_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [4:0]  row;
      logic [31:0] total;
   } row_total_type;

   logic signed [ACT_WIDTH-1:0] activations [COLUMNS];
   logic [ACC_WIDTH-1:0]        row_totals [ROWS];
   row_total_type               totals_due [$];

   // Sum of the four weight-times-activation products of one packed weight byte and its group.
   function automatic int group_dot(input logic [2:0] grp, input logic [7:0] wbyte);
      int sum;
      int weight;
      int pos;
      sum = 0;
      for (int i = 0; i < LANES; i++) begin
         weight = int'(wbyte[2*i +: 2]) - 1;
         pos = int'(grp) * LANES + i;
         if (pos < COLUMNS) begin
            sum += weight * int'(activations[pos]);
         end
      end
      return sum;
   endfunction

   always @(posedge clock) begin
      row_total_type want;
      if (reset) begin
         foreach (row_totals[r]) row_totals[r] = '0;
         foreach (activations[c]) activations[c] = '0;
         totals_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (totals_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected response: row %0d total %0d",
                           rsp_read_row, $signed(rsp_row_total));
               end
            end else begin
               want = totals_due.pop_front();
               if (rsp_read_row !== want.row || rsp_row_total !== want.total) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display({"response mismatch: expected row %0d total %0d, ",
                               "got row %0d total %0d"},
                              want.row, $signed(want.total),
                              rsp_read_row, $signed(rsp_row_total));
                  end
               end
            end
         end
         if (start && !busy) begin
            case (command_type'(req_command))
               CMD_LOAD_ACT: begin
                  activations[req_group_number*LANES + 0] = req_act_0;
                  activations[req_group_number*LANES + 1] = req_act_1;
                  activations[req_group_number*LANES + 2] = req_act_2;
                  activations[req_group_number*LANES + 3] = req_act_3;
               end
               CMD_WEIGHT: begin
                  row_totals[req_row_number] = row_totals[req_row_number]
                     + 32'(group_dot(req_group_number, req_weight_byte));
               end
               CMD_CLEAR: begin
                  foreach (row_totals[r]) row_totals[r] = '0;
               end
               default: begin
                  want.row = req_row_number;
                  want.total = row_totals[req_row_number];
                  totals_due.push_back(want);
               end
            endcase
         end
      end
      totals_due_count = totals_due.size();
   end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
module tb_top;
   import tmva_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1050;
   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [4:0]  req_row_number;
   logic [2:0]  req_group_number;
   logic [7:0]  req_act_0;
   logic [7:0]  req_act_1;
   logic [7:0]  req_act_2;
   logic [7:0]  req_act_3;
   logic [7:0]  req_weight_byte;
   logic        rsp_strobe;
   logic [4:0]  rsp_read_row;
   logic [31:0] rsp_row_total;
   int          fail_count;
   int          totals_due_count;
   int          stall_cycles;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ternary_matvec_accumulate_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_row_number   (req_row_number),
      .req_group_number (req_group_number),
      .req_act_0        (req_act_0),
      .req_act_1        (req_act_1),
      .req_act_2        (req_act_2),
      .req_act_3        (req_act_3),
      .req_weight_byte  (req_weight_byte),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_row     (rsp_read_row),
      .rsp_row_total    (rsp_row_total)
   );

   tmva_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_row_number   (req_row_number),
      .req_group_number (req_group_number),
      .req_act_0        (req_act_0),
      .req_act_1        (req_act_1),
      .req_act_2        (req_act_2),
      .req_act_3        (req_act_3),
      .req_weight_byte  (req_weight_byte),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_row     (rsp_read_row),
      .rsp_row_total    (rsp_row_total),
      .fail_count       (fail_count),
      .totals_due_count (totals_due_count)
   );

   // Waits the given number of idle cycles, then holds the transaction until it is taken.
   task automatic send(input int gap, input command_type cmd, input logic [4:0] row,
                       input logic [2:0] grp, input logic [7:0] a0, input logic [7:0] a1,
                       input logic [7:0] a2, input logic [7:0] a3, input logic [7:0] wbyte);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_command <= cmd;
      req_row_number <= row;
      req_group_number <= grp;
      req_act_0 <= a0;
      req_act_1 <= a1;
      req_act_2 <= a2;
      req_act_3 <= a3;
      req_weight_byte <= wbyte;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Activations lean toward the extremes so that the totals grow quickly.
   function automatic logic [7:0] pick_act();
      case ($urandom_range(0, 7))
         0: return 8'h80;
         1: return 8'h7f;
         2: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("ternary_matvec_accumulate_top: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int          gap;
      int          dice;
      bit          burst;
      logic [4:0]  last_row;
      command_type cmd;
      logic [4:0]  row;

      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_LOAD_ACT;
      req_row_number = '0;
      req_group_number = '0;
      req_act_0 = '0;
      req_act_1 = '0;
      req_act_2 = '0;
      req_act_3 = '0;
      req_weight_byte = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every activation position is loaded before any weight byte uses it.
      send(0, CMD_LOAD_ACT, 5'd0, 3'd0, 8'h80, 8'h7f, 8'hff, 8'h00, 8'h00);
      send(0, CMD_LOAD_ACT, 5'd0, 3'd1, 8'h7f, 8'h80, 8'h00, 8'hff, 8'h00);
      for (int g = 2; g < GROUPS; g++) begin
         send($urandom_range(0, 2), CMD_LOAD_ACT, 5'($urandom), 3'(g),
              pick_act(), pick_act(), pick_act(), pick_act(), 8'($urandom));
      end
      send(0, CMD_WEIGHT, 5'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send(0, CMD_WEIGHT, 5'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
      send(0, CMD_WEIGHT, 5'd31, 3'd7, 8'h00, 8'h00, 8'h00, 8'h00, 8'haa);
      send(0, CMD_WEIGHT, 5'd31, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55);
      send(0, CMD_WEIGHT, 5'd5, 3'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'he4);
      send(0, CMD_READ, 5'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send(0, CMD_READ, 5'd31, 3'd7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send(0, CMD_READ, 5'd5, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send(1, CMD_READ, 5'd17, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send(0, CMD_CLEAR, 5'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send(0, CMD_READ, 5'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send(0, CMD_READ, 5'd31, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send(0, CMD_WEIGHT, 5'd0, 3'd6, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
      send(0, CMD_READ, 5'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

      last_row = 5'd0;
      burst = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) burst = ($urandom_range(0, 2) == 0);
         gap = burst ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
         dice = $urandom_range(0, 99);
         if (dice < 10) cmd = CMD_LOAD_ACT;
         else if (dice < 72) cmd = CMD_WEIGHT;
         else if (dice < 74) cmd = CMD_CLEAR;
         else cmd = CMD_READ;
         // Reusing the last row exercises back-to-back updates and reads of one accumulator.
         row = ($urandom_range(0, 1) == 0) ? last_row : 5'($urandom);
         if (cmd == CMD_WEIGHT) last_row = row;
         send(gap, cmd, row, 3'($urandom), pick_act(), pick_act(), pick_act(), pick_act(),
              8'($urandom));
      end
      @(negedge clock);
      start <= 1'b0;

      while (totals_due_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0 && totals_due_count == 0) begin
         $display("ternary_matvec_accumulate_top: match");
      end else begin
         $display("ternary_matvec_accumulate_top: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
